// ===== hdl/dscu_pkg.sv =====
// ----------------------------------------------------------------------------
// dscu_pkg: shared types and constants of the disk service command unit
// Function codes, status codes, geometry field layout and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package dscu_pkg;

    // drive slot defaults
    localparam int FLOPPY_DRIVES_DEF = 2;
    localparam int HARD_DRIVES_DEF   = 2;

    // configuration port
    localparam int GEO_W     = 38;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FLOPPY_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HARD_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOPPY0_GEO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HARD0_GEO    = 3'd4;
    localparam int GEO_REGS = 2;  // geometry registers per drive class

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADCMD   = 3'd1;
    localparam logic [2:0] ST_WP       = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_CTRL     = 3'd5;
    localparam logic [2:0] ST_WFAULT   = 3'd6;

    // register write mask bits
    localparam logic [4:0] M_AH = 5'b00001;
    localparam logic [4:0] M_AL = 5'b00010;
    localparam logic [4:0] M_BL = 5'b00100;
    localparam logic [4:0] M_CX = 5'b01000;
    localparam logic [4:0] M_DX = 5'b10000;

    // service codes
    localparam logic [7:0] F_RESET      = 8'h00;
    localparam logic [7:0] F_LAST_ERR   = 8'h01;
    localparam logic [7:0] F_READ       = 8'h02;
    localparam logic [7:0] F_WRITE      = 8'h03;
    localparam logic [7:0] F_VERIFY     = 8'h04;
    localparam logic [7:0] F_FORMAT     = 8'h05;
    localparam logic [7:0] F_FMT_BAD    = 8'h06;
    localparam logic [7:0] F_FMT_DRV    = 8'h07;
    localparam logic [7:0] F_PARAMS     = 8'h08;
    localparam logic [7:0] F_INIT_PAIR  = 8'h09;
    localparam logic [7:0] F_READ_LONG  = 8'h0a;
    localparam logic [7:0] F_WRITE_LONG = 8'h0b;
    localparam logic [7:0] F_SEEK       = 8'h0c;
    localparam logic [7:0] F_ALT_RESET  = 8'h0d;
    localparam logic [7:0] F_RD_BUF     = 8'h0e;
    localparam logic [7:0] F_WR_BUF     = 8'h0f;
    localparam logic [7:0] F_TEST_RDY   = 8'h10;
    localparam logic [7:0] F_RECAL      = 8'h11;
    localparam logic [7:0] F_RAM_DIAG   = 8'h12;
    localparam logic [7:0] F_DRV_DIAG   = 8'h13;
    localparam logic [7:0] F_CTL_DIAG   = 8'h14;
    localparam logic [7:0] F_TYPE       = 8'h15;
    localparam logic [7:0] F_CHANGE     = 8'h16;
    localparam logic [7:0] F_SET_TYPE   = 8'h17;
    localparam logic [7:0] F_SET_MEDIA  = 8'h18;
    localparam logic [7:0] F_NOP_CARRY  = 8'hf9;
    localparam logic [7:0] F_EXT_CYL    = 8'hfe;

    localparam logic [7:0] HARD_BASE = 8'h80;

    // controller to datapath
    typedef struct packed {
        logic load_in;   // capture request
        logic select;    // pick drive and geometry
        logic mul1;      // first product
        logic mul2;      // second product
        logic finish;    // decode, store last error, load result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // result register can take a new item
    } t_dp_stat;

    // geometry fields
    function automatic logic geo_present(input logic [GEO_W-1:0] g);
        return g[0];
    endfunction
    function automatic logic geo_ro(input logic [GEO_W-1:0] g);
        return g[1];
    endfunction
    function automatic logic geo_rem(input logic [GEO_W-1:0] g);
        return g[2];
    endfunction
    function automatic logic [2:0] geo_cmos(input logic [GEO_W-1:0] g);
        return g[5:3];
    endfunction
    function automatic logic [7:0] geo_sect(input logic [GEO_W-1:0] g);
        return g[13:6];
    endfunction
    function automatic logic [7:0] geo_heads(input logic [GEO_W-1:0] g);
        return g[21:14];
    endfunction
    function automatic logic [15:0] geo_tracks(input logic [GEO_W-1:0] g);
        return g[37:22];
    endfunction

endpackage

// ===== hdl/dscu_ctrl.sv =====
// ----------------------------------------------------------------------------
// dscu_ctrl: request sequencer
// Steps one request through select, two multiply steps and finish, and
// holds finish until the result register is free.
// ----------------------------------------------------------------------------
module dscu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  dscu_pkg::t_dp_stat i_stat,
    output dscu_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SEL  = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_SEL;
            S_SEL:  n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_FIN;
            S_FIN:  if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands
    assign o_ready        = (r_state == S_IDLE);
    assign o_cmd.load_in  = (r_state == S_IDLE) && i_valid;
    assign o_cmd.select   = (r_state == S_SEL);
    assign o_cmd.mul1     = (r_state == S_MUL1);
    assign o_cmd.mul2     = (r_state == S_MUL2);
    assign o_cmd.finish   = (r_state == S_FIN) && i_stat.out_free;

endmodule

// ===== hdl/dscu_datapath.sv =====
// ----------------------------------------------------------------------------
// dscu_datapath: configuration, drive state and result datapath
// Holds configuration and per-slot last error, picks the drive, forms the
// LBA or capacity with two registered multiplies, and holds the result.
// ----------------------------------------------------------------------------
module dscu_datapath #(
    parameter int FLOPPY_DRIVES = dscu_pkg::FLOPPY_DRIVES_DEF,
    parameter int HARD_DRIVES   = dscu_pkg::HARD_DRIVES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dscu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dscu_pkg::GEO_W-1:0]     i_cfg_data,
    input  dscu_pkg::t_dp_cmd              i_cmd,
    output dscu_pkg::t_dp_stat             o_stat,
    input  logic [7:0]                     i_func,
    input  logic [7:0]                     i_drive_number,
    input  logic [7:0]                     i_head_in,
    input  logic [15:0]                    i_cyl_sect_word,
    input  logic [7:0]                     i_sector_count,
    input  logic                           i_ready,
    output logic                           o_valid,
    output logic [2:0]                     o_status,
    output logic                           o_carry,
    output logic [7:0]                     o_ah_value,
    output logic [7:0]                     o_al_value,
    output logic [2:0]                     o_bl_value,
    output logic [15:0]                    o_cx_value,
    output logic [15:0]                    o_dx_value,
    output logic [4:0]                     o_write_mask,
    output logic                           o_transfer_go,
    output logic                           o_transfer_write,
    output logic [31:0]                    o_lba,
    output logic                           o_motor_reload
);

    localparam int NUM_SLOTS = FLOPPY_DRIVES + HARD_DRIVES;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int FIDX_W    = (FLOPPY_DRIVES > 1) ? $clog2(FLOPPY_DRIVES) : 1;
    localparam int HIDX_W    = (HARD_DRIVES > 1) ? $clog2(HARD_DRIVES) : 1;
    localparam logic [SLOT_W-1:0] HARD_SLOT0 = SLOT_W'(FLOPPY_DRIVES);

    // configuration
    logic [1:0]                 r_floppy_count;
    logic [1:0]                 r_hard_count;
    logic [dscu_pkg::GEO_W-1:0] r_fgeo [FLOPPY_DRIVES];
    logic [dscu_pkg::GEO_W-1:0] r_hgeo [HARD_DRIVES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floppy_count <= '0;
            r_hard_count   <= '0;
            for (int i = 0; i < FLOPPY_DRIVES; i++) r_fgeo[i] <= '0;
            for (int i = 0; i < HARD_DRIVES; i++)   r_hgeo[i] <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == dscu_pkg::REG_FLOPPY_COUNT) r_floppy_count <= i_cfg_data[1:0];
            if (i_cfg_idx == dscu_pkg::REG_HARD_COUNT)   r_hard_count   <= i_cfg_data[1:0];
            for (int i = 0; i < FLOPPY_DRIVES; i++) begin
                if (i < dscu_pkg::GEO_REGS &&
                    i_cfg_idx == dscu_pkg::REG_FLOPPY0_GEO + dscu_pkg::CFG_IDX_W'(i))
                    r_fgeo[i] <= i_cfg_data;
            end
            for (int i = 0; i < HARD_DRIVES; i++) begin
                if (i < dscu_pkg::GEO_REGS &&
                    i_cfg_idx == dscu_pkg::REG_HARD0_GEO + dscu_pkg::CFG_IDX_W'(i))
                    r_hgeo[i] <= i_cfg_data;
            end
        end
    end

    // request capture
    logic [7:0]  r_func, r_disk, r_head, r_count;
    logic [15:0] r_cx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func  <= i_func;
            r_disk  <= i_drive_number;
            r_head  <= i_head_in;
            r_cx    <= i_cyl_sect_word;
            r_count <= i_sector_count;
        end
    end

    // drive selection
    logic                       sel_floppy, sel_hard;
    logic [7:0]                 hard_num;
    logic                       r_sel, r_is_floppy;
    logic [SLOT_W-1:0]          r_slot;
    logic [dscu_pkg::GEO_W-1:0] r_geo;

    assign hard_num   = r_disk - dscu_pkg::HARD_BASE;
    assign sel_floppy = (r_disk < {6'd0, r_floppy_count}) && (r_disk < 8'(FLOPPY_DRIVES));
    assign sel_hard   = (r_disk >= dscu_pkg::HARD_BASE) &&
                        (hard_num < {6'd0, r_hard_count}) && (hard_num < 8'(HARD_DRIVES));

    always_ff @(posedge i_clk) begin
        if (i_cmd.select) begin
            r_sel       <= sel_floppy || sel_hard;
            r_is_floppy <= sel_floppy;
            if (sel_floppy) begin
                r_slot <= SLOT_W'(r_disk);
                r_geo  <= r_fgeo[r_disk[FIDX_W-1:0]];
            end else if (sel_hard) begin
                r_slot <= HARD_SLOT0 + SLOT_W'(hard_num);
                r_geo  <= r_hgeo[hard_num[HIDX_W-1:0]];
            end else begin
                r_slot <= '0;
                r_geo  <= '0;
            end
        end
    end

    // geometry and address fields
    logic [7:0]  g_sect, g_heads;
    logic [15:0] g_tracks;
    logic [5:0]  sect;
    logic [9:0]  track;
    logic        is_type;

    assign g_sect   = dscu_pkg::geo_sect(r_geo);
    assign g_heads  = dscu_pkg::geo_heads(r_geo);
    assign g_tracks = dscu_pkg::geo_tracks(r_geo);
    assign sect     = r_cx[5:0];
    assign track    = {r_cx[7:6], r_cx[15:8]};
    assign is_type  = (r_func == dscu_pkg::F_TYPE);

    // multiply steps: (track*heads + head)*sect + sect-1, or tracks*heads*sect
    logic [24:0] r_m1;
    logic [31:0] r_m2;
    logic [15:0] m1_a;
    logic [32:0] m2_prod;

    assign m1_a    = is_type ? g_tracks : {6'd0, track};
    assign m2_prod = r_m1 * g_sect;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1)
            r_m1 <= {9'd0, m1_a} * {17'd0, g_heads} +
                    (is_type ? 25'd0 : {17'd0, r_head});
        if (i_cmd.mul2)
            r_m2 <= m2_prod[31:0] + (is_type ? 32'd0 : 32'({26'd0, sect} - 32'd1));
    end

    // last error per slot
    logic [2:0] r_last_err [NUM_SLOTS];

    // result decode
    logic        present;
    logic        fin, store, ah_ovr;
    logic [2:0]  code;
    logic [2:0]  n_status;
    logic        n_carry;
    logic [7:0]  n_ah, n_al, ah_alt;
    logic [2:0]  n_bl;
    logic [15:0] n_cx, n_dx, tm1;
    logic [7:0]  hm1;
    logic [4:0]  n_mask;
    logic        n_go, n_wr, n_motor;
    logic [31:0] n_lba;
    logic [1:0]  cnt;

    assign present = r_sel && dscu_pkg::geo_present(r_geo);
    assign tm1     = g_tracks - 16'd1;
    assign hm1     = g_heads - 8'd1;
    assign cnt     = (r_disk < dscu_pkg::HARD_BASE) ? r_floppy_count : r_hard_count;

    always_comb begin
        fin      = 1'b0;
        store    = 1'b0;
        ah_ovr   = 1'b0;
        ah_alt   = '0;
        code     = dscu_pkg::ST_OK;
        n_status = dscu_pkg::ST_OK;
        n_carry  = 1'b0;
        n_ah     = '0;
        n_al     = '0;
        n_bl     = '0;
        n_cx     = '0;
        n_dx     = '0;
        n_mask   = '0;
        n_go     = 1'b0;
        n_wr     = 1'b0;
        n_lba    = '0;
        n_motor  = r_is_floppy && r_sel &&
                   (r_func == dscu_pkg::F_RESET || r_func == dscu_pkg::F_READ ||
                    r_func == dscu_pkg::F_WRITE || r_func == dscu_pkg::F_FORMAT ||
                    r_func == dscu_pkg::F_READ_LONG || r_func == dscu_pkg::F_WRITE_LONG);
        unique case (r_func)
            dscu_pkg::F_RESET, dscu_pkg::F_INIT_PAIR, dscu_pkg::F_TEST_RDY,
            dscu_pkg::F_RECAL, dscu_pkg::F_RAM_DIAG, dscu_pkg::F_DRV_DIAG,
            dscu_pkg::F_CTL_DIAG: begin
                fin  = 1'b1;
                code = present ? dscu_pkg::ST_OK : dscu_pkg::ST_CTRL;
            end
            dscu_pkg::F_LAST_ERR: begin
                n_al    = r_sel ? {5'd0, r_last_err[r_slot]} : {5'd0, dscu_pkg::ST_CTRL};
                n_carry = (n_al != 8'd0);
                n_mask  = dscu_pkg::M_AL;
            end
            dscu_pkg::F_READ, dscu_pkg::F_WRITE, dscu_pkg::F_VERIFY: begin
                fin = 1'b1;
                if (!present) begin
                    code = dscu_pkg::ST_CTRL;
                end else if (r_head >= g_heads || sect == 6'd0 ||
                             {2'd0, sect} > g_sect || {6'd0, track} >= g_tracks) begin
                    code = dscu_pkg::ST_NOTFOUND;
                end else if (r_func == dscu_pkg::F_WRITE && dscu_pkg::geo_ro(r_geo)) begin
                    code = dscu_pkg::geo_rem(r_geo) ? dscu_pkg::ST_WP : dscu_pkg::ST_WFAULT;
                end else begin
                    code   = dscu_pkg::ST_OK;
                    n_go   = (r_func != dscu_pkg::F_VERIFY);
                    n_wr   = (r_func == dscu_pkg::F_WRITE);
                    n_lba  = n_go ? r_m2 : 32'd0;
                    n_al   = r_count;
                    n_mask = dscu_pkg::M_AL;
                end
            end
            dscu_pkg::F_FORMAT, dscu_pkg::F_FMT_BAD, dscu_pkg::F_FMT_DRV,
            dscu_pkg::F_RD_BUF, dscu_pkg::F_WR_BUF: begin
                fin  = 1'b1;
                code = dscu_pkg::ST_CTRL;
            end
            dscu_pkg::F_PARAMS: begin
                fin = 1'b1;
                if (!present) begin
                    code = dscu_pkg::ST_CTRL;
                end else begin
                    code   = dscu_pkg::ST_OK;
                    n_bl   = dscu_pkg::geo_cmos(r_geo);
                    n_cx   = {tm1[7:0], g_sect | {tm1[9:8], 6'd0}};
                    n_dx   = {hm1, 6'd0, cnt};
                    n_mask = dscu_pkg::M_AL | dscu_pkg::M_BL | dscu_pkg::M_CX | dscu_pkg::M_DX;
                end
            end
            dscu_pkg::F_READ_LONG, dscu_pkg::F_WRITE_LONG, dscu_pkg::F_SET_TYPE,
            dscu_pkg::F_SET_MEDIA: begin
                fin  = 1'b1;
                code = dscu_pkg::ST_BADCMD;
            end
            dscu_pkg::F_SEEK, dscu_pkg::F_ALT_RESET: begin
                fin  = 1'b1;
                code = dscu_pkg::ST_OK;
            end
            dscu_pkg::F_TYPE: begin
                fin    = 1'b1;
                ah_ovr = 1'b1;
                if (!present) begin
                    code   = dscu_pkg::ST_CTRL;
                    ah_alt = 8'd0;
                end else if (r_disk >= dscu_pkg::HARD_BASE) begin
                    n_mask = dscu_pkg::M_CX | dscu_pkg::M_DX;
                    if (dscu_pkg::geo_cmos(r_geo) != 3'd0 || dscu_pkg::geo_rem(r_geo)) begin
                        ah_alt = 8'd1;
                    end else begin
                        ah_alt = 8'd3;
                        n_cx   = r_m2[31:16];
                        n_dx   = r_m2[15:0];
                    end
                end else begin
                    ah_alt = 8'd1;
                end
            end
            dscu_pkg::F_CHANGE: begin
                if (!present) begin
                    fin  = 1'b1;
                    code = dscu_pkg::ST_CTRL;
                end else begin
                    store   = 1'b1;
                    n_mask  = dscu_pkg::M_AH;
                    n_carry = (r_disk < dscu_pkg::HARD_BASE);
                    n_ah    = (r_disk < dscu_pkg::HARD_BASE) ? 8'd6 : 8'd0;
                end
            end
            dscu_pkg::F_NOP_CARRY: begin
                n_carry = 1'b1;
            end
            dscu_pkg::F_EXT_CYL: begin
                if (r_sel) begin
                    n_dx   = {6'd0, g_tracks[9:0]};
                    n_mask = dscu_pkg::M_DX;
                end
            end
            default: begin
                fin  = 1'b1;
                code = dscu_pkg::ST_BADCMD;
            end
        endcase
        // common completion: status, AH, carry and last error
        if (fin) begin
            n_status = code;
            n_ah     = ah_ovr ? ah_alt : {5'd0, code};
            n_carry  = (code != dscu_pkg::ST_OK);
            n_mask   = n_mask | dscu_pkg::M_AH;
            store    = 1'b1;
        end
    end

    // last error update; code is OK for the change query
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) r_last_err[i] <= '0;
        end else if (i_cmd.finish && store && r_sel) begin
            r_last_err[r_slot] <= n_status;
        end
    end

    // result register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_status         <= n_status;
            o_carry          <= n_carry;
            o_ah_value       <= n_ah;
            o_al_value       <= n_al;
            o_bl_value       <= n_bl;
            o_cx_value       <= n_cx;
            o_dx_value       <= n_dx;
            o_write_mask     <= n_mask;
            o_transfer_go    <= n_go;
            o_transfer_write <= n_wr;
            o_lba            <= n_lba;
            o_motor_reload   <= n_motor;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_stat.out_free = !r_out_valid || i_ready;

endmodule

// ===== hdl/disk_service_command_unit.sv =====
// ----------------------------------------------------------------------------
// disk_service_command_unit: BIOS-style disk service request unit
// Decodes one disk service request per item, checks the drive and address,
// computes the LBA and returns the register results and transfer command.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// request   in         i_valid / o_ready    func, drive, head, cyl/sect, count
// result    out        o_valid / i_ready    status, carry, AH..DX, mask, xfer
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// An item passes from accept to result through capture at accept, drive
// select, two registered multiply steps (track*heads+head, then *sectors),
// and finish loading the result register. The next item is taken in the
// cycle after finish. One item is in work at a time; the result register
// lets the next item be accepted while a result waits. A stalled result
// holds finish until taken. Reset is synchronous, active low, and clears
// configuration and last error.
// ----------------------------------------------------------------------------
module disk_service_command_unit #(
    parameter int FLOPPY_DRIVES = dscu_pkg::FLOPPY_DRIVES_DEF,
    parameter int HARD_DRIVES   = dscu_pkg::HARD_DRIVES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dscu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dscu_pkg::GEO_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_func,
    input  logic [7:0]                     i_drive_number,
    input  logic [7:0]                     i_head_in,
    input  logic [15:0]                    i_cyl_sect_word,
    input  logic [7:0]                     i_sector_count,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [2:0]                     o_status,
    output logic                           o_carry,
    output logic [7:0]                     o_ah_value,
    output logic [7:0]                     o_al_value,
    output logic [2:0]                     o_bl_value,
    output logic [15:0]                    o_cx_value,
    output logic [15:0]                    o_dx_value,
    output logic [4:0]                     o_write_mask,
    output logic                           o_transfer_go,
    output logic                           o_transfer_write,
    output logic [31:0]                    o_lba,
    output logic                           o_motor_reload
);

    dscu_pkg::t_dp_cmd  cmd;
    dscu_pkg::t_dp_stat stat;

    dscu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    dscu_datapath #(
        .FLOPPY_DRIVES (FLOPPY_DRIVES),
        .HARD_DRIVES   (HARD_DRIVES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_func           (i_func),
        .i_drive_number   (i_drive_number),
        .i_head_in        (i_head_in),
        .i_cyl_sect_word  (i_cyl_sect_word),
        .i_sector_count   (i_sector_count),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_carry          (o_carry),
        .o_ah_value       (o_ah_value),
        .o_al_value       (o_al_value),
        .o_bl_value       (o_bl_value),
        .o_cx_value       (o_cx_value),
        .o_dx_value       (o_dx_value),
        .o_write_mask     (o_write_mask),
        .o_transfer_go    (o_transfer_go),
        .o_transfer_write (o_transfer_write),
        .o_lba            (o_lba),
        .o_motor_reload   (o_motor_reload)
    );

    // a transfer is only issued on success
    a_go_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_transfer_go |-> o_status == dscu_pkg::ST_OK && !o_carry)
        else $error("transfer issued with error status");

    // write direction only with a transfer
    a_wr_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_transfer_write |-> o_transfer_go)
        else $error("write direction without transfer");

    // an unmasked DX register reads zero
    a_dx_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_write_mask[4] |-> o_dx_value == 16'd0)
        else $error("DX set while not in write mask");

    // no new request while the previous one is still in work
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request accepted back to back");

endmodule
